### design/bezier_fade_gain_applier_top_defines.svh
// Assertion macros used by the checker of the fade gain block.
`ifndef BEZIER_FADE_GAIN_APPLIER_TOP_DEFINES_SVH
`define BEZIER_FADE_GAIN_APPLIER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BFGA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfga check failed");

// Antecedent implies consequent a fixed number of cycles later.
`define BFGA_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("bfga latency check failed");

`endif

### design/bfga_pkg.sv
// Constants and types shared by the fade gain block.
`default_nettype none
package bfga_pkg;
    localparam int CHANNELS     = 2;
    localparam int BISECT_STEPS = 24;
    localparam int FRAC_BITS    = 16;
    localparam int T_BITS       = 24;
    localparam logic [T_BITS:0] T_ONE = {1'b1, {T_BITS{1'b0}}};
    localparam logic [16:0] GAIN_ONE  = 17'h10000;
    localparam int SOLVE_LAT    = FRAC_BITS + 3 * BISECT_STEPS + 3;
    localparam int OUT_LAT      = SOLVE_LAT + 7;

    localparam logic [15:0] CTRL_X_RST = 16'd34079;
    localparam logic [15:0] CTRL_Y_RST = 16'd48497;

    typedef enum logic [2:0] {
        REG_CLIP_LENGTH     = 3'd0,
        REG_FADE_IN_LENGTH  = 3'd1,
        REG_FADE_OUT_LENGTH = 3'd2,
        REG_FADE_IN_CTRL_X  = 3'd3,
        REG_FADE_IN_CTRL_Y  = 3'd4,
        REG_FADE_OUT_CTRL_X = 3'd5,
        REG_FADE_OUT_CTRL_Y = 3'd6,
        REG_CLEAR_OUTSIDE   = 3'd7
    } t_reg_idx;
endpackage
`default_nettype wire

### design/bfga_solver.sv
// One fade curve: local x by restoring division, t by bisection, gain from y(t).
`default_nettype none
module bfga_solver (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  logic        i_falling,
    input  logic [15:0] i_ctrl_x,
    input  logic [15:0] i_ctrl_y,
    output logic        o_en,
    output logic [16:0] o_gain
);
    localparam int TW = bfga_pkg::T_BITS + 1;
    localparam int NB = bfga_pkg::BISECT_STEPS;
    localparam int NF = bfga_pkg::FRAC_BITS;

    typedef struct packed {
        logic          en;
        logic [63:0]   r;
        logic [63:0]   den;
        logic [NF-1:0] q;
    } t_frac;

    typedef struct packed {
        logic          en;
        logic [TW-1:0] lo;
        logic [TW-1:0] hi;
        logic [16:0]   tgt;
    } t_brk;

    typedef struct packed {
        t_brk               b;
        logic [TW-1:0]      mid;
        logic signed [43:0] j;
    } t_bis_a;

    typedef struct packed {
        t_brk          b;
        logic [TW-1:0] mid;
        logic [45:0]   p_lo;
        logic [45:0]   p_hi;
    } t_bis_b;

    t_frac  r_frac [NF];
    t_bis_a r_ba   [NB];
    t_bis_b r_bb   [NB];
    t_brk   r_bc   [NB];

    logic               r_ya_en;
    logic [TW-1:0]      r_ya_t;
    logic signed [43:0] r_ya_j;
    logic               r_yb_en;
    logic [45:0]        r_yb_lo;
    logic [45:0]        r_yb_hi;
    logic               r_yc_en;
    logic [16:0]        r_yc_gain;

    // The curve x(t) times 2^64 is w * (k0 + t * c1), with w equal to t on the
    // rising curve and to 1 - t on the mirrored one.
    logic signed [17:0] c1_x;
    logic signed [17:0] c1_y;
    logic [41:0]        k0_x;

    assign c1_x = $signed(18'h10000 - {1'b0, i_ctrl_x, 1'b0});
    assign c1_y = $signed({1'b0, i_ctrl_y, 1'b0} - 18'h10000);
    assign k0_x = i_falling ? 42'h100_0000_0000 : {1'b0, i_ctrl_x, 25'b0};

    genvar g;
    for (g = 0; g < NF; g++) begin : g_frac
        t_frac       src;
        t_frac       n_frac;
        logic [64:0] r2;
        if (g == 0) begin : g_first
            assign src = '{en: i_en, r: i_num, den: i_den, q: '0};
        end else begin : g_next
            assign src = r_frac[g-1];
        end
        always_comb begin
            r2 = {src.r, 1'b0};
            n_frac = src;
            n_frac.q = {src.q[NF-2:0], 1'b0};
            if (r2 >= {1'b0, src.den}) begin
                n_frac.r = 64'(r2 - {1'b0, src.den});
                n_frac.q[0] = 1'b1;
            end else begin
                n_frac.r = r2[63:0];
            end
        end
        always_ff @(posedge i_clk) begin
            r_frac[g] <= n_frac;
        end
    end

    for (g = 0; g < NB; g++) begin : g_bis
        t_brk        src;
        t_bis_a      n_ba;
        t_bis_b      n_bb;
        t_brk        n_bc;
        logic [TW:0] sum;
        logic signed [44:0] ksum;
        logic [41:0] k;
        logic [TW-1:0] w;
        logic [66:0] s;
        logic [66:0] tx;
        logic        go_lo;
        if (g == 0) begin : g_first
            logic [16:0] lx;
            assign lx  = {1'b0, r_frac[NF-1].q};
            assign src = '{en: r_frac[NF-1].en, lo: '0, hi: bfga_pkg::T_ONE,
                           tgt: i_falling ? 17'(bfga_pkg::GAIN_ONE - lx) : lx};
        end else begin : g_next
            assign src = r_bc[g-1];
        end
        always_comb begin
            sum = {1'b0, src.lo} + {1'b0, src.hi};
            n_ba.b = src;
            n_ba.mid = sum[TW:1];
            n_ba.j = $signed({1'b0, n_ba.mid}) * c1_x;
        end
        always_comb begin
            ksum = $signed({3'b000, k0_x}) + r_ba[g].j;
            k = ksum[41:0];
            w = i_falling ? TW'(bfga_pkg::T_ONE - r_ba[g].mid) : r_ba[g].mid;
            n_bb.b = r_ba[g].b;
            n_bb.mid = r_ba[g].mid;
            n_bb.p_lo = 46'(w * k[20:0]);
            n_bb.p_hi = 46'(w * k[41:21]);
        end
        always_comb begin
            s = {r_bb[g].p_hi, 21'b0} + {21'b0, r_bb[g].p_lo};
            tx = {2'b00, r_bb[g].b.tgt, 48'b0};
            go_lo = i_falling ? (s > tx + 67'd1) : (s < tx);
            n_bc = r_bb[g].b;
            if (go_lo) begin
                n_bc.lo = r_bb[g].mid;
            end else begin
                n_bc.hi = r_bb[g].mid;
            end
        end
        always_ff @(posedge i_clk) begin
            r_ba[g] <= n_ba;
            r_bb[g] <= n_bb;
            r_bc[g] <= n_bc;
        end
    end

    // y(t) uses the same form with w = 1 - t; gain is one minus y rounded.
    logic [TW:0]        y_sum;
    logic [TW-1:0]      n_ya_t;
    logic signed [44:0] y_ksum;
    logic [41:0]        y_k;
    logic [TW-1:0]      y_w;
    logic [66:0]        y_s;
    logic [18:0]        y_val;
    logic [16:0]        n_yc_gain;

    always_comb begin
        y_sum = {1'b0, r_bc[NB-1].lo} + {1'b0, r_bc[NB-1].hi};
        n_ya_t = y_sum[TW:1];
        y_ksum = $signed({3'b000, 42'h100_0000_0000}) + r_ya_j;
        y_k = y_ksum[41:0];
        y_w = TW'(bfga_pkg::T_ONE - r_ya_t);
        y_s = {r_yb_hi, 21'b0} + {21'b0, r_yb_lo} + {19'b0, 48'h8000_0000_0000};
        y_val = y_s[66:48];
        n_yc_gain = (y_val >= {2'b00, bfga_pkg::GAIN_ONE}) ? 17'd0
                  : 17'({2'b00, bfga_pkg::GAIN_ONE} - y_val);
    end

    always_ff @(posedge i_clk) begin
        r_ya_en   <= r_bc[NB-1].en;
        r_ya_t    <= n_ya_t;
        r_ya_j    <= $signed({1'b0, n_ya_t}) * c1_y;
        r_yb_en   <= r_ya_en;
        r_yb_lo   <= 46'(y_w * y_k[20:0]);
        r_yb_hi   <= 46'(y_w * y_k[41:21]);
        r_yc_en   <= r_yb_en;
        r_yc_gain <= n_yc_gain;
    end

    assign o_en   = r_yc_en;
    assign o_gain = r_yc_gain;
endmodule
`default_nettype wire

### design/bezier_fade_gain_applier_top.sv
// Top level of the quadratic Bezier fade gain block.
// Usage: pulse i_start with a frame (i_position in half samples relative to
// the clip start, two 24-bit samples). An item is taken at every rising edge
// where i_start is high and o_busy is low; o_busy is high only in reset, so
// one item per clock is sustained.
// Each item returns one result: o_done is high for one cycle with
// o_scaled_left, o_scaled_right and o_gain. The result passes through the
// two curve solvers, each 16 division stages, 24 bisection steps of three
// stages and three stages for y(t), plus seven stages of region logic, gain
// merge and sample scaling.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data. The
// user must write them only while no item is in flight; the block does not
// enforce this. They take effect at once. Reset (synchronous, active low)
// empties the pipeline and loads the register defaults. Results cannot be
// held off by the receiver: o_done must be sampled in the cycle it is shown.
`default_nettype none
module bezier_fade_gain_applier_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [32:0] i_position,
    input  logic signed [23:0] i_sample_left,
    input  logic signed [23:0] i_sample_right,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [23:0] o_scaled_left,
    output logic signed [23:0] o_scaled_right,
    output logic [16:0]        o_gain
);
    localparam int LAT = bfga_pkg::OUT_LAT;
    localparam int SL  = bfga_pkg::SOLVE_LAT;

    typedef struct packed {
        logic               zero_l;
        logic               outside;
        logic signed [23:0] left;
        logic signed [23:0] right;
    } t_frame;

    logic [30:0] r_clip_length;
    logic [30:0] r_fade_in_length;
    logic [30:0] r_fade_out_length;
    logic [15:0] r_fade_in_ctrl_x;
    logic [15:0] r_fade_in_ctrl_y;
    logic [15:0] r_fade_out_ctrl_x;
    logic [15:0] r_fade_out_ctrl_y;
    logic        r_clear_outside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_length     <= '0;
            r_fade_in_length  <= '0;
            r_fade_out_length <= '0;
            r_fade_in_ctrl_x  <= bfga_pkg::CTRL_X_RST;
            r_fade_in_ctrl_y  <= bfga_pkg::CTRL_Y_RST;
            r_fade_out_ctrl_x <= bfga_pkg::CTRL_X_RST;
            r_fade_out_ctrl_y <= bfga_pkg::CTRL_Y_RST;
            r_clear_outside   <= 1'b0;
        end else if (i_cfg_we) begin
            case (bfga_pkg::t_reg_idx'(i_cfg_index))
                bfga_pkg::REG_CLIP_LENGTH:     r_clip_length     <= i_cfg_data;
                bfga_pkg::REG_FADE_IN_LENGTH:  r_fade_in_length  <= i_cfg_data;
                bfga_pkg::REG_FADE_OUT_LENGTH: r_fade_out_length <= i_cfg_data;
                bfga_pkg::REG_FADE_IN_CTRL_X:  r_fade_in_ctrl_x  <= i_cfg_data[15:0];
                bfga_pkg::REG_FADE_IN_CTRL_Y:  r_fade_in_ctrl_y  <= i_cfg_data[15:0];
                bfga_pkg::REG_FADE_OUT_CTRL_X: r_fade_out_ctrl_x <= i_cfg_data[15:0];
                bfga_pkg::REG_FADE_OUT_CTRL_Y: r_fade_out_ctrl_y <= i_cfg_data[15:0];
                bfga_pkg::REG_CLEAR_OUTSIDE:   r_clear_outside   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic           accept;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;
    assign n_vld  = {r_vld[LAT-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 0: capture.
    logic signed [32:0] r0_pos;
    logic signed [23:0] r0_left;
    logic signed [23:0] r0_right;

    always_ff @(posedge i_clk) begin
        r0_pos   <= i_position;
        r0_left  <= i_sample_left;
        r0_right <= i_sample_right;
    end

    // Stage 1: region flags and fade lengths, rescaled when they overlap.
    logic [31:0] two_l;
    logic [30:0] len_a;
    logic [30:0] len_b;
    logic [31:0] len_ab;
    t_frame      n1_frame;
    t_frame      r1_frame;
    logic [31:0] r1_p;
    logic [31:0] r1_q;
    logic [30:0] r1_a;
    logic [30:0] r1_b;
    logic [31:0] r1_d;
    logic [31:0] r1_twol;

    always_comb begin
        two_l  = {r_clip_length, 1'b0};
        len_a  = (r_fade_in_length < r_clip_length) ? r_fade_in_length : r_clip_length;
        len_b  = (r_fade_out_length < r_clip_length) ? r_fade_out_length : r_clip_length;
        len_ab = {1'b0, len_a} + {1'b0, len_b};
        n1_frame.zero_l  = (r_clip_length == '0);
        n1_frame.outside = r0_pos[32] || (r0_pos > $signed({1'b0, two_l}));
        n1_frame.left    = r0_left;
        n1_frame.right   = r0_right;
    end

    always_ff @(posedge i_clk) begin
        r1_frame <= n1_frame;
        r1_p     <= r0_pos[31:0];
        r1_q     <= two_l - r0_pos[31:0];
        r1_a     <= len_a;
        r1_b     <= len_b;
        r1_d     <= (len_ab > {1'b0, r_clip_length}) ? len_ab : {1'b0, r_clip_length};
        r1_twol  <= two_l;
    end

    // Stage 2: scaled positions and division denominators.
    t_frame      r2_frame;
    logic [63:0] r2_pd;
    logic [63:0] r2_qd;
    logic [63:0] r2_den_in;
    logic [63:0] r2_den_out;

    always_ff @(posedge i_clk) begin
        r2_frame   <= r1_frame;
        r2_pd      <= 64'(r1_p * r1_d);
        r2_qd      <= 64'(r1_q * r1_d);
        r2_den_in  <= 64'(r1_twol * r1_a);
        r2_den_out <= 64'(r1_twol * r1_b);
    end

    // Stage 3: which fades apply.
    t_frame      r3_frame;
    logic        r3_en_in;
    logic        r3_en_out;
    logic [63:0] r3_pd;
    logic [63:0] r3_qd;
    logic [63:0] r3_den_in;
    logic [63:0] r3_den_out;

    always_ff @(posedge i_clk) begin
        r3_frame   <= r2_frame;
        r3_en_in   <= r2_pd < r2_den_in;
        r3_en_out  <= r2_qd < r2_den_out;
        r3_pd      <= r2_pd;
        r3_qd      <= r2_qd;
        r3_den_in  <= r2_den_in;
        r3_den_out <= r2_den_out;
    end

    logic        in_en;
    logic [16:0] in_gain;
    logic        out_en;
    logic [16:0] out_gain;

    bfga_solver u_fade_in (
        .i_clk    (i_clk),
        .i_en     (r3_en_in),
        .i_num    (r3_pd),
        .i_den    (r3_den_in),
        .i_falling(1'b0),
        .i_ctrl_x (r_fade_in_ctrl_x),
        .i_ctrl_y (r_fade_in_ctrl_y),
        .o_en     (in_en),
        .o_gain   (in_gain)
    );

    bfga_solver u_fade_out (
        .i_clk    (i_clk),
        .i_en     (r3_en_out),
        .i_num    (r3_qd),
        .i_den    (r3_den_out),
        .i_falling(1'b1),
        .i_ctrl_x (r_fade_out_ctrl_x),
        .i_ctrl_y (r_fade_out_ctrl_y),
        .o_en     (out_en),
        .o_gain   (out_gain)
    );

    // Frame data waits alongside the solvers.
    t_frame r_dly [SL];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r3_frame;
        for (int k = 1; k < SL; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // Merge the two gains; an inactive fade counts as unity.
    t_frame      r_gm_frame;
    logic [33:0] r_gm_prod;
    logic [16:0] gin_eff;
    logic [16:0] gout_eff;

    assign gin_eff  = in_en ? in_gain : bfga_pkg::GAIN_ONE;
    assign gout_eff = out_en ? out_gain : bfga_pkg::GAIN_ONE;

    always_ff @(posedge i_clk) begin
        r_gm_frame <= r_dly[SL-1];
        r_gm_prod  <= 34'(gin_eff * gout_eff);
    end

    t_frame      r_gf_frame;
    logic [16:0] r_gf_gain;
    logic [16:0] n_gf_gain;
    logic [33:0] gm_round;

    always_comb begin
        gm_round = r_gm_prod + 34'd32768;
        if (r_gm_frame.zero_l) begin
            n_gf_gain = bfga_pkg::GAIN_ONE;
        end else if (r_gm_frame.outside) begin
            n_gf_gain = r_clear_outside ? 17'd0 : bfga_pkg::GAIN_ONE;
        end else begin
            n_gf_gain = gm_round[32:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_gf_frame <= r_gm_frame;
        r_gf_gain  <= n_gf_gain;
    end

    // Output stage: round half up, keep 24 bits.
    logic signed [41:0] prod_l;
    logic signed [41:0] prod_r;
    logic signed [23:0] r_out_left;
    logic signed [23:0] r_out_right;
    logic [16:0]        r_out_gain;

    assign prod_l = r_gf_frame.left * $signed({1'b0, r_gf_gain}) + 42'sd32768;

    if (bfga_pkg::CHANNELS > 1) begin : g_right_scaled
        assign prod_r = r_gf_frame.right * $signed({1'b0, r_gf_gain}) + 42'sd32768;
    end else begin : g_right_pass
        assign prod_r = {r_gf_frame.right, 16'b0, 2'b00} >>> 2;
    end

    always_ff @(posedge i_clk) begin
        r_out_left  <= prod_l[39:16];
        r_out_right <= prod_r[39:16];
        r_out_gain  <= r_gf_gain;
    end

    assign o_done         = r_vld[LAT-1];
    assign o_scaled_left  = r_out_left;
    assign o_scaled_right = r_out_right;
    assign o_gain         = r_out_gain;
endmodule
`default_nettype wire

### design/bfga_checker.sv
// Port-level checks for the fade gain block, bound to the top level.
`default_nettype none
`include "bezier_fade_gain_applier_top_defines.svh"
module bfga_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input logic signed [23:0] o_scaled_left,
    input logic [16:0]        o_gain
);
    `BFGA_ASSERT_DLY(a_item_returns, i_start && !o_busy, (bfga_pkg::OUT_LAT), o_done)
    `BFGA_ASSERT_IMP(a_no_stray_result, o_done, $past(i_start && !o_busy, bfga_pkg::OUT_LAT))
    `BFGA_ASSERT_IMP(a_gain_range, o_done, o_gain <= bfga_pkg::GAIN_ONE)
    `BFGA_ASSERT_IMP(a_mute_zero, o_done && o_gain == 17'd0, o_scaled_left == 24'sd0)
endmodule

bind bezier_fade_gain_applier_top bfga_checker u_bfga_checker (.*);
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the quadratic Bezier fade gain block.
`default_nettype none
module testbench;
    import bfga_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [16:0]        gain;
    } t_frame_result;

    // Predicts the gain and scaled samples of each frame and checks results in order.
    class fade_scoreboard;
        longint unsigned clip_len, in_len, out_len;
        int unsigned in_cx, in_cy, out_cx, out_cy;
        bit clear_out;
        t_frame_result expected_frames[$];
        int errors;

        function new();
            clip_len = 0; in_len = 0; out_len = 0;
            in_cx = CTRL_X_RST; in_cy = CTRL_Y_RST;
            out_cx = CTRL_X_RST; out_cy = CTRL_Y_RST;
            clear_out = 0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [30:0] val);
            case (idx)
                REG_CLIP_LENGTH:     clip_len = val;
                REG_FADE_IN_LENGTH:  in_len = val;
                REG_FADE_OUT_LENGTH: out_len = val;
                REG_FADE_IN_CTRL_X:  in_cx = val[15:0];
                REG_FADE_IN_CTRL_Y:  in_cy = val[15:0];
                REG_FADE_OUT_CTRL_X: out_cx = val[15:0];
                REG_FADE_OUT_CTRL_Y: out_cy = val[15:0];
                REG_CLEAR_OUTSIDE:   clear_out = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned frac_q16(longint unsigned num, longint unsigned den);
            longint unsigned r;
            int unsigned q;
            r = num;
            q = 0;
            for (int i = 0; i < 16; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        // Curve coordinate at t (Q0.24), scaled by 2^63 per unit.
        function longint unsigned curve_at(int unsigned t, int unsigned p0, int unsigned p1,
                                           int unsigned p2);
            longint unsigned u, a, b, c;
            if (t == 0) return longint'(p0) << 47;
            if (t >= (1 << T_BITS)) return longint'(p2) << 47;
            u = (1 << T_BITS) - t;
            a = u * u;
            b = 2 * u * longint'(t);
            c = longint'(t) * longint'(t);
            return (a * p0 + b * p1 + c * p2) >> 1;
        endfunction

        function int unsigned solve_t(int unsigned target, int unsigned p0, int unsigned p1,
                                      int unsigned p2);
            bit rising;
            int unsigned mn, mx, lo, hi, mid;
            longint unsigned tx, x;
            rising = (p2 >= p0);
            mn = rising ? p0 : p2;
            mx = rising ? p2 : p0;
            lo = 0;
            hi = 1 << T_BITS;
            if (target < mn) target = mn;
            if (target > mx) target = mx;
            tx = longint'(target) << 47;
            for (int i = 0; i < BISECT_STEPS; i++) begin
                mid = (lo + hi) >> 1;
                x = curve_at(mid, p0, p1, p2);
                if (rising ? (x < tx) : (x > tx)) lo = mid;
                else hi = mid;
            end
            return (lo + hi) >> 1;
        endfunction

        function int unsigned gain_of_t(int unsigned t, int unsigned cy);
            longint unsigned v;
            longint unsigned y;
            v = curve_at(t, 65536, cy, 0);
            y = (v + (longint'(1) << 46)) >> 47;
            return (y >= 65536) ? 0 : 65536 - int'(y);
        endfunction

        function int unsigned envelope(longint pos);
            longint unsigned two_l, p, q, a, b, d;
            int unsigned g, lx, t, g_out;
            g = 65536;
            if (clip_len == 0) return 65536;
            two_l = 2 * clip_len;
            if (pos < 0 || longint'(pos) > longint'(two_l)) return clear_out ? 0 : 65536;
            p = pos;
            q = two_l - p;
            a = (in_len < clip_len) ? in_len : clip_len;
            b = (out_len < clip_len) ? out_len : clip_len;
            d = (a + b > clip_len) ? a + b : clip_len;
            if (p * d < two_l * a) begin
                lx = frac_q16(p * d, two_l * a);
                t = solve_t(lx, 0, in_cx, 65536);
                g = gain_of_t(t, in_cy);
            end
            if (q * d < two_l * b) begin
                lx = frac_q16(q * d, two_l * b);
                t = solve_t(65536 - lx, 65536, 65536 - out_cx, 0);
                g_out = gain_of_t(t, out_cy);
                g = int'((longint'(g) * g_out + 32768) >> 16);
            end
            return g;
        endfunction

        function logic [23:0] scale(logic signed [23:0] s, int unsigned g);
            longint v;
            v = longint'(s) * longint'(g) + 32768;
            v = v >>> 16;
            return v[23:0];
        endfunction

        function void note_frame(logic signed [32:0] pos, logic signed [23:0] l,
                                 logic signed [23:0] r);
            t_frame_result e;
            int unsigned g;
            g = envelope(longint'(pos));
            e.gain = g[16:0];
            e.left = scale(l, g);
            e.right = (CHANNELS > 1) ? scale(r, g) : r;
            expected_frames.push_back(e);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 30) $display("mismatch: %s", what);
        endtask

        task check_frame(logic signed [23:0] l, logic signed [23:0] r, logic [16:0] g);
            t_frame_result e;
            if (expected_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected result l=%0d r=%0d g=%0d", l, r, g));
                return;
            end
            e = expected_frames.pop_front();
            if (g !== e.gain)
                report_mismatch($sformatf("gain got %0d want %0d", g, e.gain));
            if (l !== e.left)
                report_mismatch($sformatf("left got %0d want %0d", l, e.left));
            if (r !== e.right)
                report_mismatch($sformatf("right got %0d want %0d", r, e.right));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [32:0] i_position;
    logic signed [23:0] i_sample_left;
    logic signed [23:0] i_sample_right;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [30:0]        i_cfg_data;
    logic               o_done;
    logic signed [23:0] o_scaled_left;
    logic signed [23:0] o_scaled_right;
    logic [16:0]        o_gain;

    fade_scoreboard sb;
    int cycle_count;
    int idle_pct;

    bezier_fade_gain_applier_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_position(i_position), .i_sample_left(i_sample_left),
        .i_sample_right(i_sample_right), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_done(o_done), .o_scaled_left(o_scaled_left),
        .o_scaled_right(o_scaled_right), .o_gain(o_gain)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_done) sb.check_frame(o_scaled_left, o_scaled_right, o_gain);
    end

    task write_reg(t_reg_idx idx, logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task load_config(logic [30:0] len, logic [30:0] fin, logic [30:0] fout,
                     logic [15:0] icx, logic [15:0] icy, logic [15:0] ocx,
                     logic [15:0] ocy, logic clr);
        write_reg(REG_CLIP_LENGTH, len);
        write_reg(REG_FADE_IN_LENGTH, fin);
        write_reg(REG_FADE_OUT_LENGTH, fout);
        write_reg(REG_FADE_IN_CTRL_X, {15'd0, icx});
        write_reg(REG_FADE_IN_CTRL_Y, {15'd0, icy});
        write_reg(REG_FADE_OUT_CTRL_X, {15'd0, ocx});
        write_reg(REG_FADE_OUT_CTRL_Y, {15'd0, ocy});
        write_reg(REG_CLEAR_OUTSIDE, {30'd0, clr});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task send_frame(logic signed [32:0] pos, logic signed [23:0] l, logic signed [23:0] r);
        if ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_position <= pos;
        i_sample_left <= l;
        i_sample_right <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_frame(pos, l, r);
    endtask

    task drain;
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.expected_frames.size() != 0) @(posedge i_clk);
        repeat (OUT_LAT + 4) @(posedge i_clk);
    endtask

    function logic signed [23:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'sh800000;
            1: return 24'sh7fffff;
            default: return $urandom;
        endcase
    endfunction

    // Most positions fall inside the clip or near its ends; a few are full-range noise.
    function logic signed [32:0] rand_position();
        longint span, p;
        span = 2 * longint'(sb.clip_len);
        case ($urandom_range(0, 9))
            0, 1: return {$urandom, $urandom};
            2, 3: begin
                p = ($urandom_range(0, 1) ? span : 0) + longint'($urandom_range(0, 40)) - 20;
                return p[32:0];
            end
            default: begin
                p = {$urandom, $urandom} % (span + 1);
                return p[32:0];
            end
        endcase
    endfunction

    function logic [30:0] rand_length(logic [30:0] len);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom;
            2: return len + $urandom_range(0, 50);
            default: return (len == 0) ? 0 : $urandom_range(0, len);
        endcase
    endfunction

    initial begin
        logic [30:0] len;
        sb = new();
        cycle_count = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_position = '0;
        i_sample_left = '0;
        i_sample_right = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero clip length after reset: unity gain everywhere.
        send_frame(33'sh100000000, 24'sh800000, 24'sh7fffff);
        send_frame(33'sh0ffffffff, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd0, 24'sd0, -24'sd1);
        drain();

        // Region edges on a short clip with silenced outside.
        load_config(31'd1000, 31'd200, 31'd300, 16'd34079, 16'd48497, 16'd34079,
                    16'd48497, 1'b1);
        send_frame(-33'sd1, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd0, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd1, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd399, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd400, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd1000, -24'sd1, 24'sd1);
        send_frame(33'sd1400, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd1401, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd2000, 24'sh7fffff, 24'sh800000);
        send_frame(33'sd2001, 24'sh7fffff, 24'sh800000);
        drain();

        // Overlapping fades are rescaled; extreme control points.
        load_config(31'd10, 31'd8, 31'd7, 16'd0, 16'd65535, 16'd65535, 16'd0, 1'b0);
        for (int p = -1; p <= 21; p += 2) send_frame(p, 24'sh7fffff, 24'sh800000);
        drain();

        load_config(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 16'd65535, 16'd0, 16'd0,
                    16'd65535, 1'b1);
        send_frame(33'sd0, 24'sh7fffff, 24'sh800000);
        send_frame(33'sh0fffffffe, 24'sh7fffff, 24'sh800000);
        send_frame(33'sh07fffffff, 24'sh7fffff, 24'sh800000);
        send_frame(33'sh0ffffffff, 24'sh7fffff, 24'sh800000);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 48 : 10);
            len = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(1, 5000));
            load_config(len, rand_length(len), rand_length(len), $urandom, $urandom,
                        $urandom, $urandom, $urandom_range(0, 1));
            for (int n = 0; n < 85; n++) send_frame(rand_position(), rand_sample(),
                                                    rand_sample());
            drain();
        end

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### bezier_fade_gain_applier_top.f
+incdir+design
design/bfga_pkg.sv
design/bfga_solver.sv
design/bezier_fade_gain_applier_top.sv
design/bfga_checker.sv
tb/testbench.sv
